@@ design/tnt_pkg.sv @@
// Shared constants, payload types and control groups for the triangle normal/tangent block.
package tnt_pkg;

    localparam int POS_WIDTH = 24;
    localparam int UV_WIDTH  = 16;
    localparam int NRM_WIDTH = 48;
    localparam int TAN_WIDTH = 32;

    // Position and UV difference widths
    localparam int PD_W   = POS_WIDTH + 1;
    localparam int UD_W   = UV_WIDTH + 1;
    // Shared multiplier operand and product widths
    localparam int MUL_W  = (PD_W > UD_W) ? PD_W : UD_W;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = PROD_W + 1;
    // Tangent numerator and UV determinant widths
    localparam int NUM_W  = PD_W + UD_W + 1;
    localparam int DET_W  = 2 * UD_W + 1;

    typedef struct packed {
        logic signed [POS_WIDTH-1:0] pos_x;
        logic signed [POS_WIDTH-1:0] pos_y;
        logic signed [POS_WIDTH-1:0] pos_z;
        logic        [UV_WIDTH-1:0]  tex_u;
        logic        [UV_WIDTH-1:0]  tex_v;
    } t_vtx;

    typedef struct packed {
        logic signed [NRM_WIDTH-1:0] normal_x;
        logic signed [NRM_WIDTH-1:0] normal_y;
        logic signed [NRM_WIDTH-1:0] normal_z;
        logic signed [TAN_WIDTH-1:0] tangent_x;
        logic signed [TAN_WIDTH-1:0] tangent_y;
        logic signed [TAN_WIDTH-1:0] tangent_z;
        logic                        degenerate;
    } t_res;

    // One multiply-accumulate operation issued to the shared unit
    typedef struct packed {
        logic vld;
        logic load;   // acc = product, else acc = acc - product
        logic last;   // flag the result once this op has accumulated
    } t_mac_op;

endpackage

@@ design/tnt_if.sv @@
// Valid/ready channel interfaces for vertex input and result output.
interface tnt_vtx_if;
    import tnt_pkg::*;
    logic valid;
    logic ready;
    t_vtx data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tnt_res_if;
    import tnt_pkg::*;
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/tnt_mac.sv @@
// Shared signed multiplier with registered product and subtracting accumulator.
module tnt_mac (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tnt_pkg::t_mac_op                 i_op,
    input  logic signed [tnt_pkg::MUL_W-1:0] i_x,
    input  logic signed [tnt_pkg::MUL_W-1:0] i_y,
    output logic                             o_done,
    output logic signed [tnt_pkg::ACC_W-1:0] o_acc
);
    import tnt_pkg::*;

    t_mac_op                   r_pop;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pop  <= '0;
            r_done <= 1'b0;
        end else begin
            r_pop  <= i_op;
            r_done <= r_pop.vld && r_pop.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_x * i_y;
        if (r_pop.vld) begin
            if (r_pop.load) begin
                r_acc <= ACC_W'(r_prod);
            end else begin
                r_acc <= r_acc - ACC_W'(r_prod);
            end
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

endmodule

@@ design/tnt_div.sv @@
// Restoring divider, one quotient bit per cycle: (num << UV_WIDTH) / den, saturated.
module tnt_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [tnt_pkg::NUM_W-1:0]     i_num,
    input  logic signed [tnt_pkg::DET_W-1:0]     i_den,
    output logic                                 o_done,
    output logic signed [tnt_pkg::TAN_WIDTH-1:0] o_quo
);
    import tnt_pkg::*;

    localparam int QB    = TAN_WIDTH + 1;          // quotient bits produced
    localparam int DVD_W = NUM_W + UV_WIDTH;       // scaled dividend width
    localparam int WID_W = DVD_W + QB;
    localparam int CMP_W = (DVD_W > DET_W) ? DVD_W : DET_W;
    localparam int CNT_W = $clog2(QB + 1);

    typedef enum logic [3:0] {
        D_IDLE = 4'b0001,
        D_PREP = 4'b0010,
        D_RUN  = 4'b0100,
        D_DONE = 4'b1000
    } t_dstate;

    t_dstate             r_state, n_state;
    logic [CNT_W-1:0]    r_cnt;
    logic [NUM_W-1:0]    r_nmag;
    logic [DET_W-1:0]    r_dmag;
    logic                r_neg;
    logic                r_sat;
    logic [DET_W-1:0]    r_rem;
    logic [QB-1:0]       r_low;
    logic [QB-1:0]       r_quo;

    logic [NUM_W-1:0]    w_nabs;
    logic [DET_W-1:0]    w_dabs;
    logic [WID_W-1:0]    w_wide;
    logic [DVD_W-1:0]    w_hi;
    logic                w_ovf;
    logic [DET_W:0]      w_trial;
    logic                w_ge;
    logic [QB-1:0]       w_lim;
    logic [QB-1:0]       w_mag;
    logic [TAN_WIDTH-1:0] w_tr;

    assign w_nabs  = i_num[NUM_W-1] ? unsigned'(-i_num) : unsigned'(i_num);
    assign w_dabs  = i_den[DET_W-1] ? unsigned'(-i_den) : unsigned'(i_den);

    // Quotient bits above the top produced bit are nonzero iff high part >= divisor
    assign w_wide  = WID_W'(r_nmag) << UV_WIDTH;
    assign w_hi    = w_wide[WID_W-1:QB];
    assign w_ovf   = CMP_W'(w_hi) >= CMP_W'(r_dmag);

    assign w_trial = {r_rem, r_low[QB-1]};
    assign w_ge    = w_trial >= {1'b0, r_dmag};

    assign w_lim   = r_neg ? (QB'(1) << (TAN_WIDTH - 1))
                           : ((QB'(1) << (TAN_WIDTH - 1)) - QB'(1));
    assign w_mag   = (r_sat || (r_quo > w_lim)) ? w_lim : r_quo;
    assign w_tr    = w_mag[TAN_WIDTH-1:0];
    assign o_quo   = signed'(r_neg ? -w_tr : w_tr);
    assign o_done  = (r_state == D_DONE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            D_IDLE: begin
                if (i_start) n_state = D_PREP;
            end
            D_PREP: begin
                n_state = w_ovf ? D_DONE : D_RUN;
            end
            D_RUN: begin
                if (r_cnt == CNT_W'(1)) n_state = D_DONE;
            end
            D_DONE: begin
                n_state = D_IDLE;
            end
            default: n_state = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == D_PREP) begin
                r_cnt <= CNT_W'(QB);
            end else if (r_state == D_RUN) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    r_nmag <= w_nabs;
                    r_dmag <= w_dabs;
                    r_neg  <= i_num[NUM_W-1] ^ i_den[DET_W-1];
                end
            end
            D_PREP: begin
                r_sat <= w_ovf;
                r_rem <= w_hi[DET_W-1:0];
                r_low <= w_wide[QB-1:0];
                r_quo <= '0;
            end
            D_RUN: begin
                if (w_ge) begin
                    r_rem <= DET_W'(w_trial - {1'b0, r_dmag});
                end else begin
                    r_rem <= w_trial[DET_W-1:0];
                end
                r_low <= r_low << 1;
                r_quo <= {r_quo[QB-2:0], w_ge};
            end
            default: begin
            end
        endcase
    end

endmodule

@@ design/triangle_normal_tangent_top.sv @@
// Triangle face normal and UV tangent unit: top level with vertex store and sequencer.
//
// Vertices arrive one per transaction on i_vtx (position Q12.12, UV Q0.16),
// three per triangle. The first two are stored while the block stays ready; the
// third starts the computation and i_vtx.ready stays low until it is done.
// One result transaction per triangle leaves on o_res: the unnormalized face
// normal (p0-p1) x (p0-p2), saturated to 48 bits, and the UV tangent
// (dp1*dv2 - dp2*dv1) / det in Q20.12, saturated. A zero UV determinant sets
// degenerate and gives a zero tangent.
// A single 25x25 multiplier with accumulator evaluates 14 products in seven
// pairs; a restoring divider then produces each tangent component at one bit
// per cycle, ends early when it must saturate, and is skipped when the UV
// determinant is zero.
// The result sits in an output register; while it waits for o_res.ready the
// block still takes the next vertices, and stalls only when the next result
// is ready before the previous one has been taken.
// Reset (i_rst_n low, synchronous) returns to the first vertex of a triangle
// and drops any pending result.
module triangle_normal_tangent_top (
    input  logic    i_clk,
    input  logic    i_rst_n,
    tnt_vtx_if.sink   i_vtx,
    tnt_res_if.source o_res
);
    import tnt_pkg::*;

    localparam logic [1:0] SLOT_V0   = 2'd0;
    localparam logic [1:0] SLOT_V1   = 2'd1;
    localparam logic [2:0] PAIR_DET  = 3'd0;
    localparam logic [2:0] PAIR_NRM0 = 3'd1;
    localparam logic [2:0] PAIR_NRM1 = 3'd2;
    localparam logic [2:0] PAIR_NRM2 = 3'd3;
    localparam logic [2:0] PAIR_TAN0 = 3'd4;
    localparam logic [2:0] PAIR_TAN1 = 3'd5;
    localparam logic [2:0] PAIR_LAST = 3'd6;
    localparam int         SAT_W     = ((ACC_W > NRM_WIDTH) ? ACC_W : NRM_WIDTH) + 1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ISSUE = 5'b00010,
        S_WAIT  = 5'b00100,
        S_DIV   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state                     r_state, n_state;
    logic [1:0]                 r_slot, n_slot;
    logic [2:0]                 r_pair, n_pair;
    logic                       r_half;
    logic                       r_out_vld;

    logic signed [POS_WIDTH-1:0] r_p0 [3];
    logic signed [POS_WIDTH-1:0] r_p1 [3];
    logic        [UV_WIDTH-1:0]  r_u0, r_v0, r_u1, r_v1;
    logic signed [PD_W-1:0]      r_a [3];
    logic signed [PD_W-1:0]      r_b [3];
    logic signed [UD_W-1:0]      r_du1, r_dv1, r_du2, r_dv2;
    logic signed [DET_W-1:0]     r_det;
    logic                        r_degen;
    logic signed [NRM_WIDTH-1:0] r_nrm [3];
    logic signed [TAN_WIDTH-1:0] r_tan [3];
    t_res                        r_out;

    logic signed [POS_WIDTH-1:0] w_pin [3];
    logic                        w_in_acc;
    logic                        w_out_acc;
    logic                        w_out_load;
    t_mac_op                     w_op;
    logic signed [MUL_W-1:0]     w_x, w_y;
    logic                        w_mac_done;
    logic signed [ACC_W-1:0]     w_acc;
    logic                        w_div_start;
    logic                        w_div_done;
    logic signed [TAN_WIDTH-1:0] w_quo;
    logic [1:0]                  w_nidx, w_tidx;

    function automatic logic signed [NRM_WIDTH-1:0] sat_nrm(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [SAT_W-1:0] w;
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        w  = SAT_W'(v);
        hi = signed'({{(SAT_W-NRM_WIDTH+1){1'b0}}, {(NRM_WIDTH-1){1'b1}}});
        lo = ~hi;
        if (w > hi) begin
            return NRM_WIDTH'(hi);
        end else if (w < lo) begin
            return NRM_WIDTH'(lo);
        end
        return NRM_WIDTH'(w);
    endfunction

    assign w_pin[0]   = i_vtx.data.pos_x;
    assign w_pin[1]   = i_vtx.data.pos_y;
    assign w_pin[2]   = i_vtx.data.pos_z;

    assign i_vtx.ready = (r_state == S_IDLE);
    assign w_in_acc    = i_vtx.valid && i_vtx.ready;
    assign w_out_acc   = r_out_vld && o_res.ready;
    assign w_out_load  = (r_state == S_OUT) && (!r_out_vld || o_res.ready);

    assign w_nidx      = 2'(r_pair - PAIR_NRM0);
    assign w_tidx      = 2'(r_pair - PAIR_TAN0);
    assign w_div_start = (r_state == S_WAIT) && w_mac_done && (r_pair >= PAIR_TAN0)
                         && !r_degen;

    // Operand pairs: det, three cross components, three tangent numerators
    always_comb begin
        w_x = '0;
        w_y = '0;
        case (r_pair)
            PAIR_DET: begin
                w_x = MUL_W'(r_half ? r_dv1 : r_du1);
                w_y = MUL_W'(r_half ? r_du2 : r_dv2);
            end
            PAIR_NRM0: begin
                w_x = MUL_W'(r_half ? r_a[2] : r_a[1]);
                w_y = MUL_W'(r_half ? r_b[1] : r_b[2]);
            end
            PAIR_NRM1: begin
                w_x = MUL_W'(r_half ? r_a[0] : r_a[2]);
                w_y = MUL_W'(r_half ? r_b[2] : r_b[0]);
            end
            PAIR_NRM2: begin
                w_x = MUL_W'(r_half ? r_a[1] : r_a[0]);
                w_y = MUL_W'(r_half ? r_b[0] : r_b[1]);
            end
            PAIR_TAN0, PAIR_TAN1, PAIR_LAST: begin
                // b*dv1 - a*dv2 == d1*dv2 - d2*dv1
                w_x = MUL_W'(r_half ? r_a[w_tidx] : r_b[w_tidx]);
                w_y = MUL_W'(r_half ? r_dv2 : r_dv1);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        w_op      = '0;
        w_op.vld  = (r_state == S_ISSUE);
        w_op.load = !r_half;
        w_op.last = r_half;
    end

    tnt_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_op),
        .i_x     (w_x),
        .i_y     (w_y),
        .o_done  (w_mac_done),
        .o_acc   (w_acc)
    );

    tnt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_acc[NUM_W-1:0]),
        .i_den   (r_det),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    always_comb begin
        n_state = r_state;
        n_slot  = r_slot;
        n_pair  = r_pair;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (r_slot == SLOT_V0 || r_slot == SLOT_V1) begin
                        n_slot = r_slot + 2'd1;
                    end else begin
                        n_slot  = SLOT_V0;
                        n_pair  = PAIR_DET;
                        n_state = S_ISSUE;
                    end
                end
            end
            S_ISSUE: begin
                if (r_half) n_state = S_WAIT;
            end
            S_WAIT: begin
                if (w_mac_done) begin
                    if (w_div_start) begin
                        n_state = S_DIV;
                    end else if (r_pair == PAIR_LAST) begin
                        n_state = S_OUT;
                    end else begin
                        n_pair  = r_pair + 3'd1;
                        n_state = S_ISSUE;
                    end
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    if (r_pair == PAIR_LAST) begin
                        n_state = S_OUT;
                    end else begin
                        n_pair  = r_pair + 3'd1;
                        n_state = S_ISSUE;
                    end
                end
            end
            S_OUT: begin
                if (w_out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_slot    <= SLOT_V0;
            r_pair    <= PAIR_DET;
            r_half    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
            r_pair  <= n_pair;
            if (r_state == S_ISSUE) begin
                r_half <= !r_half;
            end
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (w_out_acc) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Vertex store and difference registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            if (r_slot == SLOT_V0) begin
                r_p0 <= w_pin;
                r_u0 <= i_vtx.data.tex_u;
                r_v0 <= i_vtx.data.tex_v;
            end else if (r_slot == SLOT_V1) begin
                r_p1 <= w_pin;
                r_u1 <= i_vtx.data.tex_u;
                r_v1 <= i_vtx.data.tex_v;
            end else begin
                for (int i = 0; i < 3; i++) begin
                    r_a[i] <= PD_W'(r_p0[i]) - PD_W'(r_p1[i]);
                    r_b[i] <= PD_W'(r_p0[i]) - PD_W'(w_pin[i]);
                end
                r_du1 <= signed'({1'b0, r_u1}) - signed'({1'b0, r_u0});
                r_dv1 <= signed'({1'b0, r_v1}) - signed'({1'b0, r_v0});
                r_du2 <= signed'({1'b0, i_vtx.data.tex_u}) - signed'({1'b0, r_u0});
                r_dv2 <= signed'({1'b0, i_vtx.data.tex_v}) - signed'({1'b0, r_v0});
            end
        end
    end

    // Result capture
    always_ff @(posedge i_clk) begin
        if (r_state == S_WAIT && w_mac_done) begin
            if (r_pair == PAIR_DET) begin
                r_det   <= w_acc[DET_W-1:0];
                r_degen <= (w_acc == '0);
            end else if (r_pair < PAIR_TAN0) begin
                r_nrm[w_nidx] <= sat_nrm(w_acc);
            end else if (r_degen) begin
                r_tan[w_tidx] <= '0;
            end
        end
        if (r_state == S_DIV && w_div_done) begin
            r_tan[w_tidx] <= w_quo;
        end
        if (w_out_load) begin
            r_out.normal_x   <= r_nrm[0];
            r_out.normal_y   <= r_nrm[1];
            r_out.normal_z   <= r_nrm[2];
            r_out.tangent_x  <= r_tan[0];
            r_out.tangent_y  <= r_tan[1];
            r_out.tangent_z  <= r_tan[2];
            r_out.degenerate <= r_degen;
        end
    end

    assign o_res.valid = r_out_vld;
    assign o_res.data  = r_out;

endmodule

@@ design/tnt_chk.sv @@
// Port-level checker for the triangle normal/tangent block, bound to the top level.
module tnt_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          i_in_ready,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input tnt_pkg::t_res i_out_data
);
    import tnt_pkg::*;

    logic [1:0] r_vcnt;
    logic [1:0] r_pend;
    logic       r_prev_vld;
    logic       r_prev_rdy;
    logic       w_in_acc;
    logic       w_tri;
    logic       w_out_acc;
    logic       w_new;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_tri     = w_in_acc && (r_vcnt == 2'd2);
    assign w_out_acc = i_out_valid && i_out_ready;
    assign w_new     = i_out_valid && (!r_prev_vld || r_prev_rdy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcnt     <= 2'd0;
            r_pend     <= 2'd0;
            r_prev_vld <= 1'b0;
            r_prev_rdy <= 1'b0;
        end else begin
            r_prev_vld <= i_out_valid;
            r_prev_rdy <= i_out_ready;
            if (w_in_acc) begin
                r_vcnt <= (r_vcnt == 2'd2) ? 2'd0 : r_vcnt + 2'd1;
            end
            r_pend <= r_pend + {1'b0, w_tri} - {1'b0, w_out_acc};
        end
    end

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> $stable(i_out_data))
        else $error("result payload changed while stalled");

    // Degenerate UV mapping gives a zero tangent
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_data.degenerate) |->
            (i_out_data.tangent_x == '0 && i_out_data.tangent_y == '0
             && i_out_data.tangent_z == '0))
        else $error("degenerate result with nonzero tangent");

    // The third vertex of a triangle starts work: no vertex taken next cycle
    a_busy_after_tri: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tri |=> !i_in_ready)
        else $error("vertex input ready right after third vertex");

    // Each new result belongs to a completed triangle
    a_result_owed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_new |-> (r_pend != 2'd0))
        else $error("result without a completed triangle");

endmodule

bind triangle_normal_tangent_top tnt_chk u_tnt_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_vtx.valid),
    .i_in_ready  (i_vtx.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.data)
);
